// ===== rtl/stm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stripe target mapper package
// Shared types, codes and constants for the stripe target mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package stm_pkg;

  localparam int unsigned MAX_STRIPES_DEF = 16;
  localparam int unsigned TABLE_CAP       = 16;
  localparam int unsigned OFFSET_W        = 48;
  localparam int unsigned LENGTH_W        = 32;
  localparam int unsigned UNIT_W          = 32;
  localparam int unsigned WIDTH_W         = 5;
  localparam int unsigned POS_W           = 4;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned CFG_INDEX_W     = 4;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned DIV_CNT_W       = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_BYTES = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_WIDTH = CFG_INDEX_W'(1);

  localparam logic [UNIT_W-1:0]  STRIPE_BYTES_RST = UNIT_W'(1048576);
  localparam logic [WIDTH_W-1:0] STRIPE_WIDTH_RST = WIDTH_W'(1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  typedef struct packed {
    logic                action;
    logic [POS_W-1:0]    table_slot;
    logic [ID_W-1:0]     target_id;
    logic [OFFSET_W-1:0] seg_offset;
    logic [LENGTH_W-1:0] seg_length;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  hit_target;
    logic [POS_W-1:0] hit_position;
    logic             run_last;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [OFFSET_W-1:0] dividend;
    logic [UNIT_W-1:0]   divisor;
    logic [WIDTH_W-1:0]  width;
  } div_request_t;

  typedef struct packed {
    logic              done;
    logic [UNIT_W-1:0] rem;
    logic [POS_W-1:0]  pos;
  } div_result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FETCH,
    S_SEND
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/stm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/stm_divider.sv =====
// ----------------------------------------------------------------------------
// Stripe index divider
// Restoring divider, one quotient bit per cycle. Gives the byte remainder
// and the quotient reduced modulo the stripe width, folded in bit by bit.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_divider (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire stm_pkg::div_request_t req,
  output stm_pkg::div_result_t       res
);

  localparam int unsigned DW = stm_pkg::OFFSET_W;
  localparam int unsigned UW = stm_pkg::UNIT_W;
  localparam int unsigned PW = stm_pkg::POS_W;
  localparam int unsigned WW = stm_pkg::WIDTH_W;
  localparam int unsigned CW = stm_pkg::DIV_CNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [UW-1:0] part;
  logic [PW-1:0] modw;
  logic [UW-1:0] dvs;
  logic [WW-1:0] wid;

  logic [UW:0]   trial;
  logic          qbit;
  logic [UW-1:0] part_next;
  logic [WW-1:0] mod2;
  logic [PW-1:0] modw_next;

  always_comb begin
    trial     = {part, dvd[DW-1]};
    qbit      = (trial >= {1'b0, dvs});
    part_next = qbit ? UW'(trial - {1'b0, dvs}) : trial[UW-1:0];
    mod2      = {modw, qbit};
    modw_next = (mod2 >= wid) ? PW'(mod2 - wid) : mod2[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      wid  <= req.width;
      part <= '0;
      modw <= '0;
    end else if (busy) begin
      dvd  <= {dvd[DW-2:0], 1'b0};
      part <= part_next;
      modw <= modw_next;
    end
  end

  assign res.done = done;
  assign res.rem  = part;
  assign res.pos  = modw;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider reports done while still busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> (part < dvs))
    else $error("partial remainder reached the divisor");
  assert property (@(posedge clk) disable iff (rst) busy |-> ({1'b0, modw} < wid))
    else $error("folded stripe position reached the width");

endmodule

`default_nettype wire

// ===== rtl/stripe_target_mapper.sv =====
// ----------------------------------------------------------------------------
// Stripe target mapper
// Maps a byte segment of a round-robin striped file onto its targets.
// ----------------------------------------------------------------------------
// An input transfer either loads one entry of the target table (no result)
// or maps a segment. A map transfer with a nonzero length runs a
// bit-serial division of the offset by the stripe size, which also
// yields the starting table position. The block then gives one result per
// stripe unit touched, at most the stripe width (capped at the table size)
// of them, with run_last marking the final one. Each result is read from
// the table memory in S_FETCH and then offered from the registered memory
// output in S_SEND. Only one item is in flight: in_ready is high only
// while the block is idle, and it rises again in the cycle after the last
// result transfer. When the receiver stalls, the current result holds on
// the output until it is taken. Reset returns the control to idle and the
// registers to their defaults; the target table is not cleared and must be
// loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module stripe_target_mapper #(
  parameter int unsigned MAX_STRIPES = stm_pkg::MAX_STRIPES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire stm_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output stm_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [stm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [stm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned AW = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
  localparam int unsigned UW = stm_pkg::UNIT_W;
  localparam int unsigned WW = stm_pkg::WIDTH_W;
  localparam int unsigned PW = stm_pkg::POS_W;
  localparam int unsigned IW = stm_pkg::ID_W;
  localparam int unsigned LW = stm_pkg::LENGTH_W;
  localparam int unsigned WCAP_I = (MAX_STRIPES < stm_pkg::TABLE_CAP) ?
                                   MAX_STRIPES : stm_pkg::TABLE_CAP;
  localparam logic [WW-1:0] WCAP = WW'(WCAP_I);

  stm_pkg::state_t state, state_next;

  logic [UW-1:0] stripe_bytes;
  logic [WW-1:0] stripe_width;
  logic [UW-1:0] unit;
  logic [WW-1:0] width;

  logic [PW-1:0] pos;
  logic [UW:0]   rem;
  logic [WW-1:0] count;
  logic [LW-1:0] length;
  logic          last;

  logic in_xfer;
  logic out_xfer;
  logic map_start;
  logic tbl_we;

  stm_pkg::div_request_t div_req;
  stm_pkg::div_result_t  div_res;
  logic [IW-1:0]         tbl_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      stripe_bytes <= stm_pkg::STRIPE_BYTES_RST;
      stripe_width <= stm_pkg::STRIPE_WIDTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == stm_pkg::REG_STRIPE_BYTES) begin
        stripe_bytes <= cfg_data[UW-1:0];
      end else if (cfg_index == stm_pkg::REG_STRIPE_WIDTH) begin
        stripe_width <= cfg_data[WW-1:0];
      end
    end
  end

  always_comb begin
    unit  = (stripe_bytes == '0) ? UW'(1) : stripe_bytes;
    width = (stripe_width == '0) ? WW'(1) : stripe_width;
    if (width > WCAP) begin
      width = WCAP;
    end
  end

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign last     = (rem <= {1'b0, unit}) || ((count + WW'(1)) == width);

  always_comb begin
    state_next = state;
    case (state)
      stm_pkg::S_IDLE: begin
        if (in_xfer && in_data.action == stm_pkg::ACT_MAP &&
            in_data.seg_length != '0) begin
          state_next = stm_pkg::S_DIV;
        end
      end
      stm_pkg::S_DIV: begin
        if (div_res.done) begin
          state_next = stm_pkg::S_FETCH;
        end
      end
      stm_pkg::S_FETCH: begin
        state_next = stm_pkg::S_SEND;
      end
      stm_pkg::S_SEND: begin
        if (out_ready) begin
          state_next = last ? stm_pkg::S_IDLE : stm_pkg::S_FETCH;
        end
      end
      default: begin
        state_next = stm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    map_start = 1'b0;
    tbl_we    = 1'b0;
    case (state)
      stm_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        map_start = in_valid && in_data.action == stm_pkg::ACT_MAP &&
                    in_data.seg_length != '0;
        tbl_we    = in_valid && in_data.action == stm_pkg::ACT_LOAD &&
                    (32'(in_data.table_slot) < 32'(MAX_STRIPES));
      end
      stm_pkg::S_SEND: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (map_start) begin
      length <= in_data.seg_length;
    end
    if (state == stm_pkg::S_DIV && div_res.done) begin
      pos   <= div_res.pos;
      rem   <= {1'b0, div_res.rem} + {1'b0, length};
      count <= '0;
    end else if (out_xfer && !last) begin
      pos   <= (({1'b0, pos} + WW'(1)) == width) ? '0 : pos + PW'(1);
      rem   <= rem - {1'b0, unit};
      count <= count + WW'(1);
    end
  end

  assign div_req.start    = map_start;
  assign div_req.dividend = in_data.seg_offset;
  assign div_req.divisor  = unit;
  assign div_req.width    = width;

  stm_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  stm_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_STRIPES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_data.table_slot)),
    .wdata (in_data.target_id),
    .raddr (AW'(pos)),
    .rdata (tbl_rdata)
  );

  assign out_data.hit_target   = tbl_rdata;
  assign out_data.hit_position = pos;
  assign out_data.run_last     = last;

  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> ({1'b0, out_data.hit_position} < width))
    else $error("result position outside the stripe width");
  assert property (@(posedge clk) disable iff (rst)
                   (out_xfer && out_data.run_last) |=> (!out_valid && in_ready))
    else $error("block not idle after the last result of a run");
  assert property (@(posedge clk) disable iff (rst)
                   map_start |=> (state == stm_pkg::S_DIV))
    else $error("map transfer did not start the division");
  assert property (@(posedge clk) disable iff (rst)
                   div_res.done |-> (state == stm_pkg::S_DIV))
    else $error("division finished outside the division phase");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (count < width))
    else $error("more results than the stripe width");

endmodule

`default_nettype wire

// ===== verif/stm_checker.sv =====
// ----------------------------------------------------------------------------
// Stripe target mapper checker
// Watches the input, output and register ports of the stripe target mapper.
// It keeps its own copy of the target table and the stripe settings, works
// out the target hits that each accepted segment must produce, and compares
// every output transfer field by field with the oldest hit still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_checker
  import stm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire in_item_t               in_data,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire out_item_t              out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          hits_owed,
  output int                          hits_seen
);

  localparam int unsigned TABLE_DEPTH = MAX_STRIPES_DEF;
  localparam int          REPORT_MAX  = 10;

  logic [ID_W-1:0]    target_ids [TABLE_DEPTH];
  logic [UNIT_W-1:0]  unit_bytes;
  logic [WIDTH_W-1:0] width_reg;
  out_item_t          hits_due [$];
  int                 fails = 0;
  int                 seen  = 0;

  function automatic void predict_hits(input logic [OFFSET_W-1:0] offset,
                                       input logic [LENGTH_W-1:0] length);
    logic [63:0] unit;
    logic [63:0] stop;
    logic [63:0] cursor;
    int unsigned span;
    int unsigned pos;
    int unsigned count;
    out_item_t   hit;
    if (length == '0) return;
    unit = (unit_bytes == '0) ? 64'd1 : 64'(unit_bytes);
    if (width_reg == '0) begin
      span = 1;
    end else if (width_reg > TABLE_DEPTH) begin
      span = TABLE_DEPTH;
    end else begin
      span = width_reg;
    end
    stop   = 64'(offset) + 64'(length);
    cursor = 64'(offset);
    pos    = int'((cursor / unit) % 64'(span));
    count  = 0;
    while (cursor < stop && count < span) begin
      hit.hit_target   = target_ids[pos];
      hit.hit_position = POS_W'(pos);
      cursor           = (cursor / unit + 64'd1) * unit;
      count++;
      hit.run_last     = (cursor >= stop) || (count == span);
      hits_due.push_back(hit);
      pos = (pos + 1 == span) ? 0 : pos + 1;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      hits_due.delete();
      unit_bytes = STRIPE_BYTES_RST;
      width_reg  = STRIPE_WIDTH_RST;
    end else begin
      if (out_valid && out_ready) begin
        seen++;
        if (hits_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) begin
            $display("Unexpected hit transfer: target %h position %0d last %b",
                     out_data.hit_target, out_data.hit_position, out_data.run_last);
          end
        end else begin
          want = hits_due.pop_front();
          if (out_data.hit_target !== want.hit_target ||
              out_data.hit_position !== want.hit_position ||
              out_data.run_last !== want.run_last) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("Hit mismatch: expected target %h position %0d last %b, got %h %0d %b",
                       want.hit_target, want.hit_position, want.run_last,
                       out_data.hit_target, out_data.hit_position, out_data.run_last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_LOAD) begin
          target_ids[in_data.table_slot] = in_data.target_id;
        end else begin
          predict_hits(in_data.seg_offset, in_data.seg_length);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_STRIPE_BYTES: begin
            unit_bytes = cfg_data[UNIT_W-1:0];
          end
          REG_STRIPE_WIDTH: begin
            width_reg = cfg_data[WIDTH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= fails;
    hits_owed  <= hits_due.size();
    hits_seen  <= seen;
  end

endmodule

`default_nettype wire

// ===== verif/tb_stripe_target_mapper.sv =====
// ----------------------------------------------------------------------------
// Stripe target mapper testbench
// Loads the target table, then maps directed and random segments over a
// series of stripe settings and pacing modes, including zero sizes, widths
// past the table size and a long output hold-off. A separate checker predicts
// and compares every target hit; this module drives stimulus and decides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stripe_target_mapper;
  import stm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned PHASE_ITEMS   = 36;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned IDLE_PCT      = 73;
  localparam int unsigned BOTH_PCT      = 11;
  localparam int unsigned LOAD_PCT      = 15;
  localparam logic [63:0] OFFSET_MASK   = (64'd1 << OFFSET_W) - 64'd1;
  localparam logic [63:0] LENGTH_MAX    = (64'd1 << LENGTH_W) - 64'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_STRIPE_WIDTH + CFG_INDEX_W'(1);

  typedef enum int unsigned {
    PACE_STEADY,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  in_item_t               in_data    = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int                     fail_count;
  int                     hits_owed;
  int                     hits_seen;
  int unsigned            tx_idle_pct  = 0;
  int unsigned            rx_stall_pct = 0;
  logic                   hold_toggle  = 1'b0;
  logic                   hold_seen    = 1'b0;
  int unsigned            hold_left    = 0;
  logic [63:0]            unit_now     = 64'd1;
  int unsigned            span_now     = 1;
  int unsigned            loads_sent   = 0;
  int unsigned            maps_sent    = 0;
  int unsigned            cycle_count  = 0;

  stripe_target_mapper u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .hits_owed  (hits_owed),
    .hits_seen  (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver holds off for a long stretch whenever the stimulus flips the
  // hold request; otherwise it stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_STEADY: begin
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
      end
      PACE_SENDER_IDLE: begin
        tx_idle_pct = IDLE_PCT;
        rx_stall_pct <= 0;
      end
      PACE_RECEIVER_STALL: begin
        tx_idle_pct = 0;
        rx_stall_pct <= IDLE_PCT;
      end
      default: begin
        tx_idle_pct = BOTH_PCT;
        rx_stall_pct <= BOTH_PCT;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] bytes_val,
                               input logic [CFG_DATA_W-1:0] width_val,
                               input logic                  spare_write);
    logic [WIDTH_W-1:0] w;
    write_reg(REG_STRIPE_BYTES, bytes_val);
    write_reg(REG_STRIPE_WIDTH, width_val);
    if (spare_write) begin
      write_reg(CFG_INDEX_W'($urandom_range(int'(REG_SPARE_LO), (1 << CFG_INDEX_W) - 1)),
                $urandom);
    end
    cfg_we <= 1'b0;
    unit_now = (bytes_val[UNIT_W-1:0] == '0) ? 64'd1 : 64'(bytes_val[UNIT_W-1:0]);
    w = width_val[WIDTH_W-1:0];
    span_now = (w == '0) ? 1 : ((w > MAX_STRIPES_DEF) ? MAX_STRIPES_DEF : w);
  endtask

  task automatic push_item(input in_item_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.action == ACT_LOAD) begin
      loads_sent++;
    end else begin
      maps_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hits_owed != 0) @(posedge clk);
  endtask

  function automatic in_item_t load_item(input logic [POS_W-1:0] slot,
                                         input logic [ID_W-1:0] id);
    in_item_t item;
    item.action     = ACT_LOAD;
    item.table_slot = slot;
    item.target_id  = id;
    item.seg_offset = {$urandom, $urandom};
    item.seg_length = $urandom;
    return item;
  endfunction

  function automatic in_item_t map_item(input logic [63:0] offset,
                                        input logic [63:0] length);
    in_item_t item;
    item.action     = ACT_MAP;
    item.table_slot = $urandom;
    item.target_id  = $urandom;
    item.seg_offset = offset[OFFSET_W-1:0];
    item.seg_length = length[LENGTH_W-1:0];
    return item;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] base;
    logic [63:0] off;
    logic [63:0] len;
    logic [63:0] reach;
    if ($urandom_range(99) < LOAD_PCT) begin
      return load_item($urandom, $urandom);
    end
    base = {$urandom, $urandom} & OFFSET_MASK;
    case ($urandom_range(2))
      0: off = base;
      1: off = (base / unit_now) * unit_now;
      default: off = (base / unit_now + 64'd1) * unit_now - 64'd1 - $urandom_range(2);
    endcase
    reach = unit_now * (span_now + 1);
    if (reach > LENGTH_MAX) reach = LENGTH_MAX;
    case ($urandom_range(9))
      0: len = 64'd0;
      1, 2: len = {32'd0, $urandom};
      default: len = 64'd1 + ({32'd0, $urandom} % reach);
    endcase
    return map_item(off, len);
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] bytes_val;
    logic [CFG_DATA_W-1:0] width_val;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_pace(PACE_STEADY);
    apply_setting(32'd4096, 32'd4, 1'b1);

    // Every table slot is loaded before any segment can read it.
    for (int s = 0; s < TABLE_CAP; s++) begin
      push_item(load_item(POS_W'(s), ID_W'(16'h1111 * s)));
    end
    push_item(map_item(64'd0, 64'd1));
    push_item(map_item(64'd0, 64'd0));
    push_item(map_item(64'd4095, 64'd2));
    push_item(map_item(64'd4096 * 3, 64'd4097));
    push_item(map_item(64'd0, 64'd4096 * 4));
    push_item(map_item(64'd100, 64'd4096 * 9));
    push_item(map_item(OFFSET_MASK, LENGTH_MAX));
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin bytes_val = 32'd1;          width_val = 32'd16;          end
        1: begin bytes_val = 32'hFFFF_FFFF;  width_val = 32'd16;          end
        2: begin bytes_val = 32'd0;          width_val = 32'd0;           end
        3: begin bytes_val = 32'd512;        width_val = 32'hFFFF_FFF1;   end
        4: begin
          bytes_val = $urandom_range(1, 65536);
          width_val = $urandom_range(1, MAX_STRIPES_DEF);
        end
        5: begin bytes_val = 32'd3;          width_val = 32'd7;           end
        6: begin bytes_val = $urandom;       width_val = $urandom;        end
        default: begin bytes_val = 32'd1048576; width_val = 32'd1;       end
      endcase
      apply_setting(bytes_val, width_val, p[0]);
      set_pace(pace_t'(p % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) hold_toggle <= ~hold_toggle;
        if (p == 5 && n == PHASE_ITEMS / 2) wait_drained();
        push_item(random_item());
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    $display("Covered %0d table loads and %0d segment maps over %0d stripe settings,",
             loads_sent, maps_sent, NUM_PHASES + 1);
    $display("with %0d target hits checked under four pacing modes and a long hold-off.",
             hits_seen);
    if (fail_count == 0 && hits_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/stm_pkg.sv
rtl/stm_ram.sv
rtl/stm_divider.sv
rtl/stripe_target_mapper.sv
verif/stm_checker.sv
verif/tb_stripe_target_mapper.sv
